@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker tpaf_check.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define TPAF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define TPAF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ rtl/tpaf_pkg.sv @@
// Shared constants for the triangle positive-area fraction unit.
// No dependencies.
package tpaf_pkg;

   localparam int DIST_W     = 16;
   localparam int COORD_IN_W = 16;
   localparam int FRAC_OUT_W = 17;
   localparam int AREA_OUT_W = 34;
   localparam int REQ_DATA_W = 12 * 16;
   localparam int RSP_DATA_W = 88;

   // number of negative vertex distances
   localparam logic [1:0] NEG_NONE = 2'd0;
   localparam logic [1:0] NEG_ONE  = 2'd1;
   localparam logic [1:0] NEG_TWO  = 2'd2;
   localparam logic [1:0] NEG_ALL  = 2'd3;

endpackage

@@ rtl/tpaf_frac.sv @@
// Area fraction path: sort, square/denominator multiplies, restoring divider.
// Depends on tpaf_pkg. Advances on en.
module tpaf_frac #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [tpaf_pkg::DIST_W-1:0]  dist_a,
   input  logic signed [tpaf_pkg::DIST_W-1:0]  dist_b,
   input  logic signed [tpaf_pkg::DIST_W-1:0]  dist_c,
   output logic        [FRACTION_BITS:0]       frac
);

   localparam int F  = FRACTION_BITS;
   localparam int DW = tpaf_pkg::DIST_W;
   localparam int PW = 2 * DW;

   logic signed [DW-1:0] a0, a1, b1, b2, c0, c1;
   logic        [1:0]    neg_in;

   logic signed [DW-1:0] d0_ff, d1_ff, d2_ff;
   logic        [1:0]    neg1_ff;

   logic signed [DW:0]   e10, e20, e21, nd0;
   logic        [DW-1:0] m_op, op_a, op_b;
   logic        [PW-1:0] sq_in, den_in;
   logic        [PW-1:0] sq_ff, den_ff;
   logic        [1:0]    neg2_ff;
   logic        [PW-1:0] num_in;

   logic [PW-1:0] rem_ff [0:F];
   logic [PW-1:0] dd_ff  [0:F];
   logic [1:0]    ng_ff  [0:F];
   logic [F-1:0]  q_ff   [0:F];

   logic [PW:0]   trial  [1:F];
   logic          ge     [1:F];
   logic [PW-1:0] rem_in [1:F];
   logic [F-1:0]  q_in   [1:F];

   // three compare-swaps: c0 <= c1 <= b2
   always_comb begin
      a0 = (dist_a > dist_b) ? dist_b : dist_a;
      a1 = (dist_a > dist_b) ? dist_a : dist_b;
      b1 = (a1 > dist_c) ? dist_c : a1;
      b2 = (a1 > dist_c) ? a1 : dist_c;
      c0 = (a0 > b1) ? b1 : a0;
      c1 = (a0 > b1) ? a0 : b1;
      neg_in = {1'b0, c0[DW-1]} + {1'b0, c1[DW-1]} + {1'b0, b2[DW-1]};
   end

   always_comb begin
      e10 = (DW+1)'(d1_ff) - (DW+1)'(d0_ff);
      e20 = (DW+1)'(d2_ff) - (DW+1)'(d0_ff);
      e21 = (DW+1)'(d2_ff) - (DW+1)'(d1_ff);
      nd0 = -(DW+1)'(d0_ff);
      if (neg1_ff == tpaf_pkg::NEG_TWO) begin
         m_op = d2_ff;
         op_a = e20[DW-1:0];
         op_b = e21[DW-1:0];
      end else begin
         m_op = nd0[DW-1:0];
         op_a = e10[DW-1:0];
         op_b = e20[DW-1:0];
      end
      sq_in  = PW'(m_op) * PW'(m_op);
      den_in = PW'(op_a) * PW'(op_b);
   end

   // with one negative the numerator is den - d0^2
   always_comb begin
      if (neg2_ff == tpaf_pkg::NEG_TWO)
         num_in = sq_ff;
      else if (den_ff >= sq_ff)
         num_in = den_ff - sq_ff;
      else
         num_in = '0;
   end

   // one quotient bit per stage; num < den when one or two distances are negative
   always_comb begin
      for (int k = 1; k <= F; k++) begin
         trial[k]  = {rem_ff[k-1], 1'b0};
         ge[k]     = trial[k] >= {1'b0, dd_ff[k-1]};
         rem_in[k] = ge[k] ? PW'(trial[k] - {1'b0, dd_ff[k-1]}) : trial[k][PW-1:0];
         q_in[k]   = {q_ff[k-1][F-2:0], ge[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d0_ff     <= c0;
         d1_ff     <= c1;
         d2_ff     <= b2;
         neg1_ff   <= neg_in;
         sq_ff     <= sq_in;
         den_ff    <= den_in;
         neg2_ff   <= neg1_ff;
         rem_ff[0] <= num_in;
         dd_ff[0]  <= den_ff;
         ng_ff[0]  <= neg2_ff;
         q_ff[0]   <= '0;
         for (int k = 1; k <= F; k++) begin
            rem_ff[k] <= rem_in[k];
            dd_ff[k]  <= dd_ff[k-1];
            ng_ff[k]  <= ng_ff[k-1];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   always_comb begin
      case (ng_ff[F])
         tpaf_pkg::NEG_ALL:  frac = '0;
         tpaf_pkg::NEG_NONE: frac = {1'b1, {F{1'b0}}};
         default:            frac = {1'b0, q_ff[F]};
      endcase
   end

endmodule

@@ rtl/tpaf_isqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// No dependencies. Advances on en.
module tpaf_isqrt #(
   parameter int ROOT_W = 35
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic [ROOT_W-1:0]     root
);

   localparam int SW = 2 * ROOT_W;

   logic [SW-1:0] x_ff [1:ROOT_W];
   logic [SW-1:0] r_ff [1:ROOT_W];

   logic [SW-1:0] xs   [0:ROOT_W-1];
   logic [SW-1:0] rs   [0:ROOT_W-1];
   logic [SW-1:0] bitk [1:ROOT_W];
   logic [SW-1:0] tr   [1:ROOT_W];
   logic [SW-1:0] x_in [1:ROOT_W];
   logic [SW-1:0] r_in [1:ROOT_W];

   always_comb begin
      xs[0] = radicand;
      rs[0] = '0;
      for (int k = 1; k < ROOT_W; k++) begin
         xs[k] = x_ff[k];
         rs[k] = r_ff[k];
      end
      for (int k = 1; k <= ROOT_W; k++) begin
         bitk[k] = SW'(1) << (2 * (ROOT_W - k));
         tr[k]   = rs[k-1] + bitk[k];
         if (xs[k-1] >= tr[k]) begin
            x_in[k] = xs[k-1] - tr[k];
            r_in[k] = (rs[k-1] >> 1) + bitk[k];
         end else begin
            x_in[k] = xs[k-1];
            r_in[k] = rs[k-1] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= ROOT_W; k++) begin
            x_ff[k] <= x_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign root = r_ff[ROOT_W][ROOT_W-1:0];

endmodule

@@ rtl/triangle_positive_area_fraction_unit.sv @@
// Top level of the triangle positive-area fraction unit; depends on tpaf_pkg,
// tpaf_frac and tpaf_isqrt. Each transfer on req carries one triangle (three
// Q8.8 vertex distances, three vertices) and yields one transfer on rsp with the
// positive-side area fraction (Q1.FRACTION_BITS), the triangle area and the
// positive part of that area. A new triangle is taken every cycle unless rsp
// stalls; at the defaults the geometry path, ending in the square-root
// pipeline that resolves one root bit per stage, is longer than the fraction path.
// The whole pipeline holds while a result waits on rsp and rsp_tready is low.
module triangle_positive_area_fraction_unit #(
   parameter int COORD_WIDTH   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // dist_a, dist_b, dist_c, vert_a_x, vert_a_y, vert_a_z,
   // vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z (16 bits each)
   input  logic [tpaf_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // area_fraction[16:0], tri_area[50:17], plus_area[84:51], zero pad[87:85]
   output logic [tpaf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int CW  = COORD_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int IW  = tpaf_pkg::COORD_IN_W;
   localparam int EW  = (CW > IW) ? CW : IW;
   localparam int UW  = CW + 1;
   localparam int PRW = 2 * CW + 2;
   localparam int XW  = 2 * CW + 3;
   localparam int MW  = 2 * CW + 2;
   localparam int RW  = MW + 1;
   localparam int SW  = 2 * RW;
   localparam int H   = (MW + 1) / 2;
   localparam int HW  = MW - H;
   localparam int AW  = RW - 1;
   localparam int FW  = F + 1;
   localparam int H2  = (AW + 1) / 2;
   localparam int A2  = AW - H2;
   localparam int PW  = AW + FW;
   localparam int OAW = tpaf_pkg::AREA_OUT_W;
   localparam int OFW = tpaf_pkg::FRAC_OUT_W;
   localparam int LF  = 3 + F;
   localparam int LG  = 6 + RW;
   localparam int L   = (LF > LG) ? LF : LG;
   localparam int DF  = L - LF;
   localparam int DG  = L - LG;
   localparam int N   = L + 2;

   logic en;
   logic vld_ff [0:N-1];

   assign en         = !vld_ff[N-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < N; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // ---------------- fraction path
   logic [FW-1:0] frac_u, frac_d;

   tpaf_frac #(.FRACTION_BITS(F)) u_frac (
      .clock  (clock),
      .en     (en),
      .dist_a ($signed(req_tdata[15:0])),
      .dist_b ($signed(req_tdata[31:16])),
      .dist_c ($signed(req_tdata[47:32])),
      .frac   (frac_u)
   );

   // ---------------- geometry path
   logic [EW-1:0]        cext [0:8];
   logic signed [CW-1:0] pc   [0:8];
   logic signed [UW-1:0] uv_in [0:5];
   logic signed [UW-1:0] uv_ff [0:5];
   logic signed [PRW-1:0] pr_in [0:5];
   logic signed [PRW-1:0] pr_ff [0:5];
   logic signed [XW-1:0] cr    [0:2];
   logic [XW-1:0]        cmag  [0:2];
   logic [MW-1:0]        mag_ff [0:2];
   logic [2*HW-1:0]      hh_ff [0:2];
   logic [HW+H-1:0]      hl_ff [0:2];
   logic [2*H-1:0]       ll_ff [0:2];
   logic [SW-1:0]        csq_in [0:2];
   logic [SW-1:0]        csq_ff [0:2];
   logic [SW-1:0]        s_ff;
   logic [RW-1:0]        root_u, root_d;

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         cext[i] = EW'(req_tdata[48 + 16*i +: 16]);
         pc[i]   = $signed(cext[i][CW-1:0]);
      end
      for (int i = 0; i < 3; i++) begin
         uv_in[i]     = UW'(pc[3+i]) - UW'(pc[i]);
         uv_in[3 + i] = UW'(pc[6+i]) - UW'(pc[i]);
      end
      // uy*vz, uz*vy, uz*vx, ux*vz, ux*vy, uy*vx
      pr_in[0] = PRW'(uv_ff[1]) * PRW'(uv_ff[5]);
      pr_in[1] = PRW'(uv_ff[2]) * PRW'(uv_ff[4]);
      pr_in[2] = PRW'(uv_ff[2]) * PRW'(uv_ff[3]);
      pr_in[3] = PRW'(uv_ff[0]) * PRW'(uv_ff[5]);
      pr_in[4] = PRW'(uv_ff[0]) * PRW'(uv_ff[4]);
      pr_in[5] = PRW'(uv_ff[1]) * PRW'(uv_ff[3]);
      for (int i = 0; i < 3; i++) begin
         cr[i]     = XW'(pr_ff[2*i]) - XW'(pr_ff[2*i+1]);
         cmag[i]   = cr[i][XW-1] ? XW'(-cr[i]) : XW'(cr[i]);
         // square of hi:lo split into three narrow products
         csq_in[i] = (SW'(hh_ff[i]) << (2*H)) + (SW'(hl_ff[i]) << (H+1))
                     + SW'(ll_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 6; i++) begin
            uv_ff[i] <= uv_in[i];
            pr_ff[i] <= pr_in[i];
         end
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= cmag[i][MW-1:0];
            hh_ff[i]  <= (2*HW)'(mag_ff[i][MW-1:H]) * (2*HW)'(mag_ff[i][MW-1:H]);
            hl_ff[i]  <= (HW+H)'(mag_ff[i][MW-1:H]) * (HW+H)'(mag_ff[i][H-1:0]);
            ll_ff[i]  <= (2*H)'(mag_ff[i][H-1:0]) * (2*H)'(mag_ff[i][H-1:0]);
            csq_ff[i] <= csq_in[i];
         end
         s_ff <= csq_ff[0] + csq_ff[1] + csq_ff[2];
      end
   end

   tpaf_isqrt #(.ROOT_W(RW)) u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (s_ff),
      .root     (root_u)
   );

   // ---------------- line the two paths up
   if (DF == 0) begin : g_frac_direct
      assign frac_d = frac_u;
   end else begin : g_frac_delay
      logic [FW-1:0] fd_ff [0:DF-1];
      always_ff @(posedge clock) begin
         if (en) begin
            fd_ff[0] <= frac_u;
            for (int i = 1; i < DF; i++) fd_ff[i] <= fd_ff[i-1];
         end
      end
      assign frac_d = fd_ff[DF-1];
   end

   if (DG == 0) begin : g_root_direct
      assign root_d = root_u;
   end else begin : g_root_delay
      logic [RW-1:0] rd_ff [0:DG-1];
      always_ff @(posedge clock) begin
         if (en) begin
            rd_ff[0] <= root_u;
            for (int i = 1; i < DG; i++) rd_ff[i] <= rd_ff[i-1];
         end
      end
      assign root_d = rd_ff[DG-1];
   end

   // ---------------- area times fraction, output register
   logic [AW-1:0]      area_in;
   logic [AW-1:0]      area1_ff;
   logic [FW-1:0]      frac1_ff;
   logic [H2+FW-1:0]   plo_ff;
   logic [A2+FW-1:0]   phi_ff;
   logic [PW-1:0]      prod;
   logic [PW+OAW-1:0]  plus_x;
   logic [AW+OAW-1:0]  area_x;
   logic [FW+OFW-1:0]  frac_x;
   logic [OFW-1:0]     frac_o_ff;
   logic [OAW-1:0]     area_o_ff;
   logic [OAW-1:0]     plus_o_ff;

   assign area_in = root_d[RW-1:1];

   always_comb begin
      prod   = (PW'(phi_ff) << H2) + PW'(plo_ff);
      plus_x = (PW+OAW)'(prod) >> F;
      area_x = (AW+OAW)'(area1_ff);
      frac_x = (FW+OFW)'(frac1_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         area1_ff  <= area_in;
         frac1_ff  <= frac_d;
         plo_ff    <= (H2+FW)'(area_in[H2-1:0]) * (H2+FW)'(frac_d);
         phi_ff    <= (A2+FW)'(area_in[AW-1:H2]) * (A2+FW)'(frac_d);
         frac_o_ff <= frac_x[OFW-1:0];
         area_o_ff <= area_x[OAW-1:0];
         plus_o_ff <= plus_x[OAW-1:0];
      end
   end

   assign rsp_tdata = {3'b000, plus_o_ff, area_o_ff, frac_o_ff};

endmodule

@@ rtl/tpaf_check.sv @@
// Port-level checks for the triangle positive-area fraction unit, bound to the top.
// Depends on tpaf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpaf_check (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [tpaf_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   // stalled result holds
   `TPAF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // empty output never blocks the input
   `TPAF_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // a stalled result stops intake so nothing is overwritten
   `TPAF_ASSERT_IMP(a_stall_blocks, clock, reset, rsp_tvalid && !rsp_tready, !req_tready)
   // pad bits above plus_area stay clear
   `TPAF_ASSERT_IMP(a_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[87:85] == 3'b000)

endmodule

bind triangle_positive_area_fraction_unit tpaf_check u_tpaf_check (.*);

@@ tb/triangle_positive_area_fraction_unit_checker.sv @@
// Checker for the triangle positive-area fraction unit: watches req and rsp,
// predicts each result from the accepted triangle and compares field by field.
// Depends on tpaf_pkg.
`timescale 1ns / 1ps
module triangle_positive_area_fraction_unit_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tpaf_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tpaf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output int                              fail_count,
   output int                              pending_count
);

   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic [tpaf_pkg::AREA_OUT_W-1:0] plus_area;
      logic [tpaf_pkg::AREA_OUT_W-1:0] tri_area;
      logic [tpaf_pkg::FRAC_OUT_W-1:0] area_fraction;
   } tri_result_type;

   tri_result_type expected_results[$];

   function automatic logic [tpaf_pkg::FRAC_OUT_W-1:0] positive_fraction(
         input logic signed [15:0] da, input logic signed [15:0] db,
         input logic signed [15:0] dc);
      longint d0, d1, d2, t, num, den, sq, q;
      int neg;
      d0 = da; d1 = db; d2 = dc;
      if (d0 > d1) begin t = d0; d0 = d1; d1 = t; end
      if (d1 > d2) begin t = d1; d1 = d2; d2 = t; end
      if (d0 > d1) begin t = d0; d0 = d1; d1 = t; end
      neg = (d0 < 0) + (d1 < 0) + (d2 < 0);
      if (neg == 3) return 0;
      if (neg == 0) return 1 << FRAC_BITS;
      if (neg == 2) begin
         num = d2 * d2;
         den = (d2 - d0) * (d2 - d1);
      end else begin
         sq  = d0 * d0;
         den = (d1 - d0) * (d2 - d0);
         num = (den >= sq) ? den - sq : 0;
      end
      q = (num << FRAC_BITS) / den;
      if (q > (1 << FRAC_BITS)) q = 1 << FRAC_BITS;
      return q[tpaf_pkg::FRAC_OUT_W-1:0];
   endfunction

   function automatic tri_result_type predict_triangle(
         input logic [tpaf_pkg::REQ_DATA_W-1:0] d);
      tri_result_type r;
      longint p[9];
      longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
      logic [127:0] mx, my, mz;
      logic [127:0] s, root, trial;
      logic [63:0] area;
      logic [127:0] prod;
      for (int i = 0; i < 9; i++) p[i] = $signed(d[(3+i)*16 +: 16]);
      r.area_fraction = positive_fraction(d[15:0], d[31:16], d[47:32]);
      ux = p[3] - p[0]; uy = p[4] - p[1]; uz = p[5] - p[2];
      vx = p[6] - p[0]; vy = p[7] - p[1]; vz = p[8] - p[2];
      cx = uy * vz - uz * vy;
      cy = uz * vx - ux * vz;
      cz = ux * vy - uy * vx;
      // squares of 35-bit components need more than 64 bits
      mx = 128'((cx < 0) ? -cx : cx);
      my = 128'((cy < 0) ? -cy : cy);
      mz = 128'((cz < 0) ? -cz : cz);
      s = mx * mx + my * my + mz * mz;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= s) root = trial;
      end
      area = root[63:0] >> 1;
      r.tri_area = area[tpaf_pkg::AREA_OUT_W-1:0];
      prod = 128'(area) * 128'(r.area_fraction);
      r.plus_area = prod[FRAC_BITS +: tpaf_pkg::AREA_OUT_W];
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      tri_result_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         expected_results.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_triangle(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[84:0];
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transfer, expected none, actual %h",
                        $time, rsp_tdata);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (got.area_fraction !== want.area_fraction) begin
                  $display("%0t: area_fraction expected %0d actual %0d", $time,
                           want.area_fraction, got.area_fraction);
                  errs++;
               end
               if (got.tri_area !== want.tri_area) begin
                  $display("%0t: tri_area expected %0d actual %0d", $time,
                           want.tri_area, got.tri_area);
                  errs++;
               end
               if (got.plus_area !== want.plus_area) begin
                  $display("%0t: plus_area expected %0d actual %0d", $time,
                           want.plus_area, got.plus_area);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

@@ tb/triangle_positive_area_fraction_unit_tb.sv @@
// Top of the testbench: clock, reset, triangle stimulus with random gaps and
// rsp backpressure, and the verdict. Depends on tpaf_pkg, the unit and its checker.
`timescale 1ns / 1ps
module triangle_positive_area_fraction_unit_tb;

   localparam int LATENCY     = 43;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic                            clock = 0;
   logic                            reset = 1;
   logic                            req_tvalid = 0;
   logic                            req_tready;
   logic [tpaf_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 0;
   logic [tpaf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   int                              fail_count, pending_count;
   int                              cycle_count = 0;
   bit                              calm = 0;     // no idling near the end
   bit                              hold_rsp = 0;

   always #5 clock = ~clock;

   triangle_positive_area_fraction_unit uut (.*);

   triangle_positive_area_fraction_unit_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver: random stall bursts, and one long hold once hold_rsp is set
   initial begin
      int n;
      bit held;
      held = 0;
      @(negedge reset);
      forever begin
         if (hold_rsp && !held) begin
            held = 1;
            rsp_tready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            n = $urandom_range(8, 1);
            rsp_tready <= 0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_tready <= 1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [15:0] rand_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(512)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_triangle(input logic [15:0] f[12]);
      int n;
      if (!calm && $urandom_range(3) == 0) begin
         n = $urandom_range(8, 1);
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      for (int i = 0; i < 12; i++) req_tdata[i*16 +: 16] <= f[i];
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_random();
      logic [15:0] f[12];
      for (int i = 0; i < 12; i++) f[i] = rand_value();
      send_triangle(f);
   endtask

   task automatic send_dists(input logic [15:0] a, b, c);
      logic [15:0] f[12];
      f = '{a, b, c, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0000, 16'h0100, 16'h0000};
      send_triangle(f);
   endtask

   initial begin
      logic [15:0] f[12];
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // sign patterns, zero distances, ties, extremes
      send_dists(16'hff00, 16'hfe00, 16'hfd00);
      send_dists(16'h0100, 16'h0200, 16'h0300);
      send_dists(16'h0000, 16'h0000, 16'h0000);
      send_dists(16'hff00, 16'h0000, 16'h0000);
      send_dists(16'hff00, 16'hff00, 16'h0000);
      send_dists(16'hff00, 16'hff00, 16'h0100);
      send_dists(16'hff00, 16'h0100, 16'h0100);
      send_dists(16'h8000, 16'h7fff, 16'h7fff);
      send_dists(16'h8000, 16'h8000, 16'h7fff);
      send_dists(16'h7fff, 16'h8000, 16'hffff);
      send_dists(16'h0001, 16'hffff, 16'h0000);
      // degenerate triangles
      f = '{16'hff00, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
            16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 16'h0100};
      send_triangle(f);
      f = '{16'hff00, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
            16'h0100, 16'h0100, 16'h0100, 16'h0200, 16'h0200, 16'h0200};
      send_triangle(f);
      // largest area
      f = '{16'h0100, 16'hff00, 16'hff00, 16'h8000, 16'h8000, 16'h8000,
            16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff};
      send_triangle(f);
      f = '{16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
            16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000};
      send_triangle(f);
      // long rsp hold so the pipeline fills and stalls req
      hold_rsp = 1;
      for (int i = 0; i < 120; i++) send_random();
      req_tvalid <= 0;
      // pause until the unit has drained
      while (pending_count != 0) @(posedge clock);
      for (int i = 0; i < 600; i++) send_random();
      calm = 1;
      for (int i = 0; i < 120; i++) send_random();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
